/* src/mfu_pkg.sv */
`default_nettype none

package mfu_pkg;

	localparam int NUM_W = 16;
	localparam int POW_W = 2;
	localparam int TOT_W = 16;
	localparam int CNT_W = 8;
	localparam int SIG_W = 49;
	localparam int TBL_W = 16;

	localparam logic [POW_W-1:0] MAX_POWER = 2'd3;

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic [POW_W-1:0] power;
		logic             trivial;
	} item_t;

endpackage

`default_nettype wire

/* src/multiplicative_function_unit_core.sv */
`default_nettype none

// Multiplicative function unit: Euler totient, Carmichael lambda, divisor
// count and divisor sum sigma_s of a 16-bit number.
// Command channel: drive number and power with start; the query transfers at
// the rising edge where start is high and busy is low. A power above three is
// clamped to three; power zero makes divisor_sigma the divisor count.
// Result channel: done is high for exactly one cycle with the four results;
// the receiver cannot stall, so take the transfer in that cycle.
// A two-entry queue between the front end and the factoring engine lets two
// further queries transfer while one is being worked on.
// Sequencing: queries are worked one at a time. Numbers 0, 1 and those not
// below MAX_N answer 1 everywhere without factoring. Otherwise each prime
// division is a table read and a 16-step divider; each distinct prime adds
// binary gcd steps for the lcm and then the steps of the sigma term.
// Reset: busy is held high while a clearing pass over all MAX_N entries
// empties the factor table and the sieve then fills it.
module multiplicative_function_unit_core #(
	parameter int MAX_N = 65536
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [mfu_pkg::NUM_W-1:0]  number,
	input  wire logic [mfu_pkg::POW_W-1:0]  power,
	output logic                            done,
	output logic      [mfu_pkg::TOT_W-1:0]  totient,
	output logic      [mfu_pkg::TOT_W-1:0]  carmichael,
	output logic      [mfu_pkg::CNT_W-1:0]  divisor_count,
	output logic      [mfu_pkg::SIG_W-1:0]  divisor_sigma
);

	logic                      ready;
	logic                      pop;
	logic                      q_valid;
	mfu_pkg::item_t            q_item;
	logic [mfu_pkg::NUM_W-1:0] tbl_addr;
	logic [mfu_pkg::TBL_W-1:0] tbl_data;

	// front end: classify and hold queries
	mfu_front #(.MAX_N(MAX_N)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.number  (number),
		.power   (power),
		.ready   (ready),
		.pop     (pop),
		.busy    (busy),
		.q_valid (q_valid),
		.q_item  (q_item)
	);

	// least factor table, cleared and sieved after reset
	mfu_table #(.MAX_N(MAX_N)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (tbl_addr),
		.rdata  (tbl_data),
		.ready  (ready)
	);

	// factoring engine: walk the table, accumulate the four functions
	mfu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (pop),
		.tbl_addr      (tbl_addr),
		.tbl_data      (tbl_data),
		.done          (done),
		.totient       (totient),
		.carmichael    (carmichael),
		.divisor_count (divisor_count),
		.divisor_sigma (divisor_sigma)
	);

endmodule

`default_nettype wire

/* src/mfu_front.sv */
`default_nettype none

module mfu_front #(
	parameter int MAX_N = 65536
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [mfu_pkg::NUM_W-1:0]  number,
	input  wire logic [mfu_pkg::POW_W-1:0]  power,
	input  wire logic                       ready,
	input  wire logic                       pop,
	output logic                            busy,
	output logic                            q_valid,
	output mfu_pkg::item_t                  q_item
);

	logic [1:0]     cnt_q;
	logic           wp_q;
	logic           rp_q;
	mfu_pkg::item_t ent_q [2];
	mfu_pkg::item_t item;
	logic           push;

	assign busy    = !ready || (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = ent_q[rp_q];

	// classify: nothing to factorize below two or beyond the table
	always_comb begin
		item.number  = number;
		item.power   = (power > mfu_pkg::MAX_POWER) ? mfu_pkg::MAX_POWER : power;
		item.trivial = (number < 16'd2) || (32'(number) >= MAX_N);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= item;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule

`default_nettype wire

/* src/mfu_table.sv */
`default_nettype none

module mfu_table #(
	parameter int MAX_N = 65536
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [mfu_pkg::NUM_W-1:0]  raddr,
	output logic      [mfu_pkg::TBL_W-1:0]  rdata,
	output logic                            ready
);

	localparam int AW = $clog2(MAX_N);
	localparam int SW = 2 * AW;
	localparam logic [AW-1:0] LAST = AW'(MAX_N - 1);

	typedef enum logic [2:0] {T_CLR, T_IRD, T_ICHK, T_JRD, T_JCHK, T_DONE} tstate_t;

	tstate_t                   state_q;
	logic [AW-1:0]             i_q;
	logic [AW:0]               j_q;
	logic [SW-1:0]             sq_q;
	logic [mfu_pkg::TBL_W-1:0] tbl_mem [MAX_N];
	logic [mfu_pkg::TBL_W-1:0] rd_q;
	logic                      we;
	logic [AW-1:0]             wa;
	logic [AW-1:0]             ra;
	logic [AW:0]               j_next;

	assign rdata  = rd_q;
	assign ready  = (state_q == T_DONE);
	assign j_next = j_q + {1'b0, i_q};

	always_comb begin
		we = 1'b0;
		wa = i_q;
		ra = i_q;
		case (state_q)
			T_CLR:  we = 1'b1;
			T_ICHK: we = (rd_q == '0);
			T_JRD:  ra = j_q[AW-1:0];
			T_JCHK: begin
				we = (rd_q == '0);
				wa = j_q[AW-1:0];
			end
			T_DONE: ra = AW'(raddr);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			tbl_mem[wa] <= (state_q == T_CLR) ? '0 : mfu_pkg::TBL_W'(i_q);
		end
		rd_q <= tbl_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_CLR;
			i_q     <= '0;
		end else begin
			case (state_q)
				T_CLR: begin
					if (i_q == LAST) begin
						i_q     <= AW'(2);
						state_q <= T_IRD;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				T_IRD: begin
					sq_q    <= i_q * i_q;
					state_q <= T_ICHK;
				end
				T_ICHK: begin
					if ((rd_q == '0) && ({1'b0, sq_q} < (SW + 1)'(MAX_N))) begin
						j_q     <= sq_q[AW:0];
						state_q <= T_JRD;
					end else if (i_q == LAST) begin
						state_q <= T_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= T_IRD;
					end
				end
				T_JRD: state_q <= T_JCHK;
				T_JCHK: begin
					if (j_next < (AW + 1)'(MAX_N)) begin
						j_q     <= j_next;
						state_q <= T_JRD;
					end else if (i_q == LAST) begin
						state_q <= T_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= T_IRD;
					end
				end
				T_DONE: ;
				default: state_q <= T_CLR;
			endcase
		end
	end

	a_sieve_factor: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q != T_CLR) |-> i_q >= AW'(2)) else $error("sieve writes factor below two");

endmodule

`default_nettype wire

/* src/mfu_back.sv */
`default_nettype none

module mfu_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	input  wire mfu_pkg::item_t             q_item,
	output logic                            q_pop,
	output logic      [mfu_pkg::NUM_W-1:0]  tbl_addr,
	input  wire logic [mfu_pkg::TBL_W-1:0]  tbl_data,
	output logic                            done,
	output logic      [mfu_pkg::TOT_W-1:0]  totient,
	output logic      [mfu_pkg::TOT_W-1:0]  carmichael,
	output logic      [mfu_pkg::CNT_W-1:0]  divisor_count,
	output logic      [mfu_pkg::SIG_W-1:0]  divisor_sigma
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_LOOK, S_DIV, S_PHI, S_PHI2, S_GCD, S_LDIV, S_LMUL, S_TERM, S_SMUL
	} state_t;

	state_t      state_q;
	logic        done_q;
	logic [15:0] r_q, p_q, pk1_q, phi_q, lam_q, cphi_q, ccar_q;
	logic [4:0]  k_q, t_q;
	logic [7:0]  cnt_q;
	logic [1:0]  s_q, j_q, c_q;
	logic [48:0] sig_q, term_q, sum_q, acc_q;
	logic [15:0] ga_q, gb_q;
	logic [3:0]  gz_q;
	logic [15:0] dv_rem_q, dv_quo_q, dv_d_q;
	logic [3:0]  dv_cnt_q;

	logic [48:0] mul_a;
	logic [15:0] mul_b;
	logic [64:0] mul_p;
	logic [63:0] sum_ext;
	logic [15:0] chunk;
	logic [48:0] acc_n;
	logic [16:0] dv_trial, dv_sub;
	logic        dv_ge;
	logic [15:0] dv_rem_n, dv_quo_n;
	logic [15:0] pr, ccar_n;
	logic [7:0]  kp1;

	assign q_pop         = (state_q == S_IDLE) && q_valid;
	assign tbl_addr      = r_q;
	assign done          = done_q;
	assign totient       = phi_q;
	assign carmichael    = lam_q;
	assign divisor_count = cnt_q;
	assign divisor_sigma = sig_q;

	// restoring divider, one quotient bit a cycle
	assign dv_trial = {dv_rem_q, dv_quo_q[15]};
	assign dv_sub   = dv_trial - {1'b0, dv_d_q};
	assign dv_ge    = (dv_trial >= {1'b0, dv_d_q});
	assign dv_rem_n = dv_ge ? dv_sub[15:0] : dv_trial[15:0];
	assign dv_quo_n = {dv_quo_q[14:0], dv_ge};

	assign pr      = ((tbl_data < 16'd2) || (tbl_data > r_q)) ? r_q : tbl_data;
	assign ccar_n  = ((p_q == 16'd2) && (k_q > 5'd2)) ? (pk1_q >> 1) : cphi_q;
	assign kp1     = 8'(k_q) + 8'd1;
	assign sum_ext = {15'd0, sum_q};
	assign chunk   = 16'(sum_ext >> {c_q, 4'b0000});
	assign mul_p   = mul_a * mul_b;
	assign acc_n   = acc_q + 49'(mul_p << {c_q, 4'b0000});

	// one shared multiplier, operands chosen by step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_LOOK: begin mul_a = 49'(pk1_q);    mul_b = p_q;           end
			S_PHI:  begin mul_a = 49'(pk1_q);    mul_b = p_q - 16'd1;   end
			S_PHI2: begin mul_a = 49'(phi_q);    mul_b = cphi_q;        end
			S_LMUL: begin mul_a = 49'(dv_quo_q); mul_b = ccar_q;        end
			S_TERM: begin mul_a = term_q;        mul_b = p_q;           end
			S_SMUL: begin mul_a = sig_q;         mul_b = chunk;         end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						s_q   <= q_item.power;
						r_q   <= q_item.number;
						k_q   <= '0;
						phi_q <= 16'd1;
						lam_q <= 16'd1;
						cnt_q <= 8'd1;
						sig_q <= 49'd1;
						if (q_item.trivial) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_LOOK;
				S_LOOK: begin
					if (k_q == '0) begin
						p_q      <= pr;
						pk1_q    <= 16'd1;
						dv_rem_q <= '0;
						dv_quo_q <= r_q;
						dv_d_q   <= pr;
						dv_cnt_q <= '0;
						state_q  <= S_DIV;
					end else if (tbl_data == p_q) begin
						pk1_q    <= mul_p[15:0];
						dv_rem_q <= '0;
						dv_quo_q <= r_q;
						dv_d_q   <= p_q;
						dv_cnt_q <= '0;
						state_q  <= S_DIV;
					end else begin
						state_q <= S_PHI;
					end
				end
				S_DIV, S_LDIV: begin
					dv_rem_q <= dv_rem_n;
					dv_quo_q <= dv_quo_n;
					dv_cnt_q <= dv_cnt_q + 4'd1;
					if (dv_cnt_q == 4'd15) begin
						if (state_q == S_LDIV) begin
							state_q <= S_LMUL;
						end else begin
							r_q     <= dv_quo_n;
							k_q     <= k_q + 5'd1;
							state_q <= (dv_quo_n == 16'd1) ? S_PHI : S_RD;
						end
					end
				end
				S_PHI: begin
					cphi_q  <= mul_p[15:0];
					state_q <= S_PHI2;
				end
				S_PHI2: begin
					phi_q   <= mul_p[15:0];
					ccar_q  <= ccar_n;
					ga_q    <= lam_q;
					gb_q    <= ccar_n;
					gz_q    <= '0;
					state_q <= S_GCD;
				end
				S_GCD: begin
					if (ga_q == '0) begin
						dv_rem_q <= '0;
						dv_quo_q <= lam_q;
						dv_d_q   <= 16'(gb_q << gz_q);
						dv_cnt_q <= '0;
						state_q  <= S_LDIV;
					end else if (!ga_q[0] && !gb_q[0]) begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						gz_q <= gz_q + 4'd1;
					end else if (!ga_q[0]) begin
						ga_q <= ga_q >> 1;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else if (ga_q >= gb_q) begin
						ga_q <= ga_q - gb_q;
					end else begin
						gb_q <= gb_q - ga_q;
					end
				end
				S_LMUL: begin
					lam_q   <= mul_p[15:0];
					cnt_q   <= 8'(cnt_q * kp1);
					term_q  <= 49'd1;
					sum_q   <= 49'd1;
					t_q     <= '0;
					j_q     <= '0;
					state_q <= S_TERM;
				end
				S_TERM: begin
					if (t_q == k_q) begin
						acc_q   <= '0;
						c_q     <= '0;
						state_q <= S_SMUL;
					end else if (j_q == s_q) begin
						sum_q <= sum_q + term_q;
						t_q   <= t_q + 5'd1;
						j_q   <= '0;
					end else begin
						term_q <= mul_p[48:0];
						j_q    <= j_q + 2'd1;
					end
				end
				S_SMUL: begin
					acc_q <= acc_n;
					c_q   <= c_q + 2'd1;
					if (c_q == 2'd3) begin
						sig_q <= acc_n;
						if (r_q == 16'd1) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							k_q     <= '0;
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_LDIV) |-> dv_d_q != '0)
		else $error("divide by zero");
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GCD) |-> gb_q != '0) else $error("gcd operand lost");

endmodule

`default_nettype wire
